@@ sv/kle_pkg.sv @@
`default_nettype none

package kle_pkg;

   // Line store size; one slot stays free so a line never exceeds this many results
   localparam int LINE_CAPACITY = 64;
   localparam int LEN_W         = (LINE_CAPACITY > 2) ? $clog2(LINE_CAPACITY) : 1;
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_CAPACITY - 1);

   // Scancode constants (set 1)
   localparam int            KEY_TABLE_LEN  = 58;
   localparam int            KEY_IDX_W      = $clog2(KEY_TABLE_LEN);
   localparam logic [7:0]    SC_LSHIFT      = 8'h2A;
   localparam logic [7:0]    SC_RSHIFT      = 8'h36;
   localparam logic [7:0]    SC_BREAK       = 8'h80;
   localparam logic [6:0]    CH_NEWLINE     = 7'h0A;
   localparam logic [6:0]    CH_BACKSPACE   = 7'h08;
   localparam logic [6:0]    CH_NONE        = 7'h00;

   typedef enum logic [1:0] {
      EV_ECHO  = 2'd0,
      EV_ERASE = 2'd1,
      EV_CHAR  = 2'd2,
      EV_END   = 2'd3
   } kle_event_type;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_FLUSH,
      KIND_SHIFT_ON,
      KIND_SHIFT_OFF,
      KIND_CHAR,
      KIND_ERASE,
      KIND_ENTER
   } kle_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EMIT,
      ST_FINISH
   } kle_state_type;

   typedef struct packed {
      logic          clr_len;
      logic          dec_len;
      logic          wr_char;
      logic          set_shift;
      logic          clr_shift;
      logic          start_rd;
      logic          rd_next;
      logic          load_out;
      kle_event_type out_ev;
      logic          out_last;
      logic          idle;
   } kle_cmd_type;

   typedef struct packed {
      kle_kind_type kind;
      logic         len_zero;
      logic         len_full;
      logic         rd_done;
      logic         out_free;
   } kle_status_type;

   localparam logic [6:0] KEYS_PLAIN [KEY_TABLE_LEN] = '{
      7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
      7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
      7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
      7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
      7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
   };

   localparam logic [6:0] KEYS_SHIFTED [KEY_TABLE_LEN] = '{
      7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
      7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
      7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
      7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
      7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
   };

endpackage

`default_nettype wire

@@ sv/kle_req_if.sv @@
`default_nettype none

interface kle_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] scancode;

   modport source (output valid, output action, output scancode, input ready);
   modport sink   (input valid, input action, input scancode, output ready);
endinterface

`default_nettype wire

@@ sv/kle_rsp_if.sv @@
`default_nettype none

interface kle_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_res;
   logic [6:0] character;
   logic       last;

   modport source (output valid, output event_res, output character, output last,
                   input ready);
   modport sink   (input valid, input event_res, input character, input last,
                   output ready);
endinterface

`default_nettype wire

@@ sv/kle_ctrl.sv @@
`default_nettype none

module kle_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire kle_pkg::kle_status_type status,
   output kle_pkg::kle_cmd_type         cmd
);
   import kle_pkg::*;

   kle_state_type state_ff;
   kle_state_type state_in;
   logic          req_fire;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.out_ev = EV_ECHO;
      cmd.idle  = (state_ff == ST_IDLE);
      req_ready = 1'b0;
      req_fire  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = status.out_free;
            req_fire  = req_valid && status.out_free;
            if (req_fire) begin
               case (status.kind)
                  KIND_FLUSH: begin
                     cmd.clr_len   = 1'b1;
                     cmd.clr_shift = 1'b1;
                  end
                  KIND_SHIFT_ON:  cmd.set_shift = 1'b1;
                  KIND_SHIFT_OFF: cmd.clr_shift = 1'b1;
                  KIND_CHAR: begin
                     if (!status.len_full) begin
                        cmd.wr_char  = 1'b1;
                        cmd.load_out = 1'b1;
                        cmd.out_ev   = EV_ECHO;
                        cmd.out_last = 1'b1;
                     end
                  end
                  KIND_ERASE: begin
                     if (!status.len_zero) begin
                        cmd.dec_len  = 1'b1;
                        cmd.load_out = 1'b1;
                        cmd.out_ev   = EV_ERASE;
                        cmd.out_last = 1'b1;
                     end
                  end
                  KIND_ENTER: state_in = ST_READ;
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            // Fetch the first stored character, or go straight to the end marker
            if (status.len_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.start_rd = 1'b1;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // Hand out one character and prefetch the next
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_ev   = EV_CHAR;
               if (status.rd_done) begin
                  state_in = ST_FINISH;
               end else begin
                  cmd.rd_next = 1'b1;
               end
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_ev   = EV_END;
               cmd.out_last = 1'b1;
               cmd.clr_len  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

@@ sv/kle_datapath.sv @@
`default_nettype none

module kle_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_action,
   input  wire logic [7:0]            req_scancode,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_event_res,
   output logic [6:0]                 rsp_character,
   output logic                       rsp_last,
   input  wire kle_pkg::kle_cmd_type  cmd,
   output kle_pkg::kle_status_type    status
);
   import kle_pkg::*;

   logic             shift_ff;
   logic             shift_in;
   logic [LEN_W-1:0] len_ff;
   logic [LEN_W-1:0] len_in;
   logic [LEN_W-1:0] rd_ptr_ff;
   logic [LEN_W-1:0] rd_addr;
   logic             rd_en;
   logic [6:0]       rd_data_ff;
   logic [6:0]       line_mem [LINE_CAPACITY];
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [1:0]       rsp_event_ff;
   logic [6:0]       rsp_char_ff;
   logic [6:0]       out_char;
   logic             rsp_last_ff;
   logic [KEY_IDX_W-1:0] key_idx;
   logic [6:0]       key_char;
   kle_kind_type     kind;

   // Decode the request against the key tables
   assign key_idx  = req_scancode[KEY_IDX_W-1:0];
   assign key_char = shift_ff ? KEYS_SHIFTED[key_idx] : KEYS_PLAIN[key_idx];

   always_comb begin
      if (req_action) begin
         kind = KIND_FLUSH;
      end else if (req_scancode == SC_LSHIFT || req_scancode == SC_RSHIFT) begin
         kind = KIND_SHIFT_ON;
      end else if (req_scancode == (SC_LSHIFT | SC_BREAK) ||
                   req_scancode == (SC_RSHIFT | SC_BREAK)) begin
         kind = KIND_SHIFT_OFF;
      end else if (req_scancode[7]) begin
         kind = KIND_NONE;
      end else if (req_scancode[6:0] >= 7'(KEY_TABLE_LEN)) begin
         kind = KIND_NONE;
      end else if (key_char == CH_NONE) begin
         kind = KIND_NONE;
      end else if (key_char == CH_NEWLINE) begin
         kind = KIND_ENTER;
      end else if (key_char == CH_BACKSPACE) begin
         kind = KIND_ERASE;
      end else begin
         kind = KIND_CHAR;
      end
   end

   // Shift and line length
   always_comb begin
      shift_in = shift_ff;
      if (cmd.set_shift) begin
         shift_in = 1'b1;
      end else if (cmd.clr_shift) begin
         shift_in = 1'b0;
      end
      len_in = len_ff;
      if (cmd.clr_len) begin
         len_in = '0;
      end else if (cmd.dec_len) begin
         len_in = len_ff - 1'b1;
      end else if (cmd.wr_char) begin
         len_in = len_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 1'b0;
         len_ff   <= '0;
      end else begin
         shift_ff <= shift_in;
         len_ff   <= len_in;
      end
   end

   // Line store: write at the tail, read out from the head
   assign rd_en   = cmd.start_rd || cmd.rd_next;
   assign rd_addr = cmd.start_rd ? '0 : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_char) begin
         line_mem[len_ff] <= key_char;
      end
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
         rd_ptr_ff  <= rd_addr + 1'b1;
      end
   end

   // Result register
   always_comb begin
      case (cmd.out_ev)
         EV_ECHO: out_char = key_char;
         EV_CHAR: out_char = rd_data_ff;
         default: out_char = CH_NONE;
      endcase
      rsp_valid_in = cmd.load_out ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_event_ff <= cmd.out_ev;
         rsp_char_ff  <= out_char;
         rsp_last_ff  <= cmd.out_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = rsp_event_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   // Status toward the controller
   assign status.kind     = kind;
   assign status.len_zero = (len_ff == '0);
   assign status.len_full = (len_ff == LEN_LIMIT);
   assign status.rd_done  = (rd_ptr_ff == len_ff);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

endmodule

`default_nettype wire

@@ sv/keyboard_scancode_line_editor_unit.sv @@
// Echo and erase results appear in the cycle after the request is taken; shift,
// flush and ignored codes give no result.
// Enter: ST_READ, read data register, ST_EMIT, result register; then one per cycle
// from the line store read port while the result is not stalled, end marker last.
// Synchronous reset clears shift, line length, controller and result valid;
// the line store is not cleared and needs no clearing pass.
`default_nettype none

module keyboard_scancode_line_editor_unit (
   input  wire logic clock,
   input  wire logic reset,
   kle_req_if.sink   req,
   kle_rsp_if.source rsp
);
   import kle_pkg::*;

   kle_cmd_type    cmd;
   kle_status_type status;

   kle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   kle_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_action    (req.action),
      .req_scancode  (req.scancode),
      .rsp_ready     (rsp.ready),
      .rsp_valid     (rsp.valid),
      .rsp_event_res (rsp.event_res),
      .rsp_character (rsp.character),
      .rsp_last      (rsp.last),
      .cmd           (cmd),
      .status        (status)
   );

`ifndef SYNTHESIS
   // No new request while a line is being read out
   a_busy_no_req: assert property (@(posedge clock) disable iff (reset)
      !cmd.idle |-> !req.ready)
      else $error("request accepted during line readout");

   // End marker always closes the item
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.event_res == EV_END |-> rsp.last)
      else $error("line end without last");

   // Line characters never close the item
   a_char_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.event_res == EV_CHAR |-> !rsp.last)
      else $error("line char flagged last");

   // Echo always carries a real character
   a_echo_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.event_res == EV_ECHO |-> rsp.character != CH_NONE && rsp.last)
      else $error("bad echo result");
`endif

endmodule

`default_nettype wire

@@ test/tb_keyboard_scancode_line_editor_unit.sv @@
`timescale 1ns / 1ps

module tb_keyboard_scancode_line_editor_unit;
   import kle_pkg::*;

   localparam logic ACT_KEY   = 1'b0;
   localparam logic ACT_FLUSH = 1'b1;

   // Set-1 make codes used by the directed requests
   localparam logic [7:0] KEY_NONE  = 8'h00;
   localparam logic [7:0] KEY_ESC   = 8'h01;
   localparam logic [7:0] KEY_1     = 8'h02;
   localparam logic [7:0] KEY_BKSP  = 8'h0E;
   localparam logic [7:0] KEY_TAB   = 8'h0F;
   localparam logic [7:0] KEY_ENTER = 8'h1C;
   localparam logic [7:0] KEY_CTRL  = 8'h1D;
   localparam logic [7:0] KEY_A     = 8'h1E;
   localparam logic [7:0] KEY_STAR  = 8'h37;
   localparam logic [7:0] KEY_ALT   = 8'h38;
   localparam logic [7:0] KEY_SPACE = 8'h39;
   localparam logic [7:0] KEY_OVER  = 8'h3A;
   localparam logic [7:0] KEY_TOP   = 8'h7F;

   localparam int RANDOM_KEYS  = 450;
   localparam int DRAIN_CYCLES = LINE_CAPACITY + 16;

   typedef struct {
      kle_event_type ev;
      logic [6:0]    ch;
      logic          last;
   } line_event_type;

   // Shadow of the editor: shift state, line contents and the events still owed
   class line_echo_board;
      logic [7:0]  plain_keys   [KEY_TABLE_LEN];
      logic [7:0]  shifted_keys [KEY_TABLE_LEN];
      logic        shift_down;
      int unsigned line_len;
      logic [6:0]  line_chars [LINE_CAPACITY];
      line_event_type expected_events [$];
      int unsigned fails;

      function new();
         plain_keys = '{
            8'd0, 8'h1B, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=",
            8'h08, 8'h09, "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]",
            8'h0A, 8'd0, "a", "s", "d", "f", "g", "h", "j", "k", "l", ";", "'", 8'h60,
            8'd0, "\\", "z", "x", "c", "v", "b", "n", "m", ",", ".", "/", 8'd0,
            "*", 8'd0, " "
         };
         shifted_keys = '{
            8'd0, 8'h1B, "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "_", "+",
            8'h08, 8'h09, "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}",
            8'h0A, 8'd0, "A", "S", "D", "F", "G", "H", "J", "K", "L", ":", "\"", "~",
            8'd0, "|", "Z", "X", "C", "V", "B", "N", "M", "<", ">", "?", 8'd0,
            "*", 8'd0, " "
         };
         shift_down = 1'b0;
         line_len   = 0;
         fails      = 0;
      endfunction

      function void owe(kle_event_type ev, logic [6:0] ch, logic last);
         expected_events.push_back(line_event_type'{ev, ch, last});
      endfunction

      // Apply one accepted request and queue the events it must produce
      function void note_keystroke(logic act, logic [7:0] code);
         logic [6:0] ch;
         if (act == ACT_FLUSH) begin
            line_len   = 0;
            shift_down = 1'b0;
         end else if (code == SC_LSHIFT || code == SC_RSHIFT) begin
            shift_down = 1'b1;
         end else if (code == (SC_LSHIFT | SC_BREAK) || code == (SC_RSHIFT | SC_BREAK)) begin
            shift_down = 1'b0;
         end else if (!code[7] && code < KEY_TABLE_LEN) begin
            ch = shift_down ? shifted_keys[code][6:0] : plain_keys[code][6:0];
            if (ch == CH_NEWLINE) begin
               for (int i = 0; i < line_len; i++) owe(EV_CHAR, line_chars[i], 1'b0);
               owe(EV_END, CH_NONE, 1'b1);
               line_len = 0;
            end else if (ch == CH_BACKSPACE) begin
               if (line_len > 0) begin
                  line_len--;
                  owe(EV_ERASE, CH_NONE, 1'b1);
               end
            end else if (ch != CH_NONE && line_len < LINE_CAPACITY - 1) begin
               // keep one slot free; a full line drops the key silently
               line_chars[line_len] = ch;
               line_len++;
               owe(EV_ECHO, ch, 1'b1);
            end
         end
      endfunction

      // Compare one accepted event against the oldest one owed
      function void check_event(logic [1:0] ev, logic [6:0] ch, logic last);
         line_event_type want;
         if (expected_events.size() == 0) begin
            $display("%0t: unexpected event, expected none got ev=%0d ch=%h last=%b",
                     $time, ev, ch, last);
            fails++;
            return;
         end
         want = expected_events.pop_front();
         if (ev !== want.ev) begin
            $display("%0t: event mismatch, expected %0d got %0d", $time, want.ev, ev);
            fails++;
         end
         if (ch !== want.ch) begin
            $display("%0t: character mismatch, expected %h got %h", $time, want.ch, ch);
            fails++;
         end
         if (last !== want.last) begin
            $display("%0t: last mismatch, expected %b got %b", $time, want.last, last);
            fails++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic idle_on = 1'b1;
   int   key_count = 0;
   line_echo_board board;

   kle_req_if req_bus ();
   kle_rsp_if rsp_bus ();

   keyboard_scancode_line_editor_unit u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Offer one request, with an occasional idle burst first, and hold until taken
   task automatic send_key(input logic act, input logic [7:0] code);
      if (idle_on && $urandom_range(0, 9) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.action   <= act;
      req_bus.scancode <= code;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.note_keystroke(act, code);
   endtask

   // Hold the sender off until every owed event has come back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (board.expected_events.size() != 0);
   endtask

   // Make code of a key that lands in the line
   function automatic logic [7:0] typed_code();
      logic [7:0] c;
      do c = 8'($urandom_range(1, KEY_TABLE_LEN - 1));
      while (c inside {KEY_BKSP, KEY_ENTER, KEY_CTRL, SC_LSHIFT, SC_RSHIFT, KEY_ALT});
      return c;
   endfunction

   // Code the editor should drop: releases, unmapped keys, or any byte at all
   function automatic logic [7:0] stray_code();
      case ($urandom_range(0, 5))
         0: return {1'b1, 7'($urandom)};
         1: return 8'($urandom_range(KEY_TABLE_LEN, 127));
         2: return KEY_CTRL;
         3: return KEY_ALT;
         4: return KEY_NONE;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] shift_code(input logic release_it);
      logic [7:0] c;
      c = ($urandom_range(0, 1) != 0) ? SC_LSHIFT : SC_RSHIFT;
      return release_it ? (c | SC_BREAK) : c;
   endfunction

   // Type a line of mixed keys, then mostly close it with enter
   task automatic random_line(input int n_keys);
      int roll;
      for (int k = 0; k < n_keys; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 68) begin
            send_key(ACT_KEY, typed_code());
            key_count++;
         end else if (roll < 77) begin
            send_key(ACT_KEY, KEY_BKSP);
            key_count++;
         end else if (roll < 83) begin
            send_key(ACT_KEY, shift_code(1'b0));
            key_count++;
         end else if (roll < 89) begin
            send_key(ACT_KEY, shift_code(1'b1));
            key_count++;
         end else if (roll < 98) begin
            send_key(ACT_KEY, stray_code());
            key_count++;
         end else begin
            send_key(ACT_FLUSH, 8'($urandom));
            key_count++;
         end
      end
      roll = $urandom_range(0, 19);
      if (roll < 17) begin
         send_key(ACT_KEY, KEY_ENTER);
         key_count++;
      end else if (roll < 19) begin
         send_key(ACT_FLUSH, 8'($urandom));
         key_count++;
      end
   endtask

   // Fill the line with plain keys, then read it out
   task automatic full_line(input int n_chars);
      for (int k = 0; k < n_chars; k++) send_key(ACT_KEY, typed_code());
      send_key(ACT_KEY, KEY_ENTER);
      key_count += n_chars + 1;
   endtask

   // Event sink: check every accepted event and stall in random bursts
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            board.check_event(rsp_bus.event_res, rsp_bus.character, rsp_bus.last);
         if (stall_left == 0 && idle_on && $urandom_range(0, 11) == 0)
            stall_left = $urandom_range(1, 11);
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= !reset;
         end
      end
   end

   initial begin
      #8_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      int line_no;
      board = new();
      req_bus.valid    <= 1'b0;
      req_bus.action   <= ACT_KEY;
      req_bus.scancode <= KEY_NONE;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-line keys, both shifts, drops, edge codes, flush
      send_key(ACT_FLUSH, 8'hFF);
      send_key(ACT_KEY, KEY_ENTER);
      send_key(ACT_KEY, KEY_BKSP);
      send_key(ACT_KEY, KEY_A);
      send_key(ACT_KEY, SC_LSHIFT);
      send_key(ACT_KEY, KEY_1);
      send_key(ACT_KEY, SC_LSHIFT | SC_BREAK);
      send_key(ACT_KEY, SC_RSHIFT);
      send_key(ACT_KEY, KEY_A);
      send_key(ACT_KEY, KEY_STAR);
      send_key(ACT_KEY, SC_RSHIFT | SC_BREAK);
      send_key(ACT_KEY, KEY_A | SC_BREAK);
      send_key(ACT_KEY, KEY_NONE);
      send_key(ACT_KEY, KEY_CTRL);
      send_key(ACT_KEY, KEY_OVER);
      send_key(ACT_KEY, KEY_TOP);
      send_key(ACT_KEY, KEY_ESC);
      send_key(ACT_KEY, KEY_TAB);
      send_key(ACT_KEY, KEY_SPACE);
      send_key(ACT_KEY, KEY_BKSP);
      send_key(ACT_KEY, KEY_ENTER);
      send_key(ACT_KEY, SC_LSHIFT);
      send_key(ACT_FLUSH, KEY_NONE);
      send_key(ACT_KEY, KEY_A);
      send_key(ACT_KEY, KEY_ENTER);
      wait_drained();

      // Random lines; a few fill the line to and past capacity
      line_no = 0;
      while (key_count < RANDOM_KEYS) begin
         if (RANDOM_KEYS - key_count < 90) idle_on = 1'b0;
         if (line_no == 2) full_line(LINE_CAPACITY + 2);
         else if (line_no == 9) full_line(LINE_CAPACITY - 1);
         else if (line_no == 15) full_line(LINE_CAPACITY - 2);
         else if ($urandom_range(0, 7) == 0) random_line($urandom_range(10, 40));
         else random_line($urandom_range(0, 10));
         if (line_no == 12) wait_drained();
         line_no++;
      end

      // Let the last line read out, then give the block time to go quiet
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (board.expected_events.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.fails == 0 && board.expected_events.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
